[sv/sbpbm_pkg.sv]
// Shared types and constants for the stereo block peak bar meter.
// No dependencies; imported by every module of the block.
package sbpbm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int ACC_W      = 19;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE = 16'sd32767;
    localparam logic [5:0] LAST_SECOND = 6'd59;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [6:0] LAST_HOUR   = 7'd98;

    localparam logic [15:0] FPB_RESET = 16'd1024;
    localparam logic [7:0]  BW_RESET  = 8'd30;
    localparam logic [17:0] FPS_RESET = 18'd44100;

    typedef enum logic [1:0] {
        CFG_FRAMES_PER_BLOCK  = 2'd0,
        CFG_BAR_WIDTH         = 2'd1,
        CFG_FRAMES_PER_SECOND = 2'd2
    } t_cfg_idx;

    // one finished block: channel extremes plus the stamp it carries
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lmin;
        logic signed [SAMPLE_W-1:0] lmax;
        logic signed [SAMPLE_W-1:0] rmin;
        logic signed [SAMPLE_W-1:0] rmax;
        logic                       stamp_valid;
        logic [6:0]                 hours;
        logic [5:0]                 minutes;
        logic [5:0]                 seconds;
    } t_row;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

[sv/sbpbm_front.sv]
// Front end: takes frames, tracks per-channel extremes, closes blocks and
// runs the time stamp clock. Depends on sbpbm_pkg.
module sbpbm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic signed [15:0]   i_left,
    input  logic signed [15:0]   i_right,
    input  logic                 i_eos,
    input  logic [15:0]          i_frames_per_block,
    input  logic [17:0]          i_frames_per_second,
    output logic                 o_push,
    output sbpbm_pkg::t_row      o_row
);
    import sbpbm_pkg::*;

    logic signed [15:0] r_lmin, r_lmax, r_rmin, r_rmax;
    logic signed [15:0] n_lmin, n_lmax, n_rmin, n_rmax;
    logic [15:0]        r_fib, n_fib;
    logic [ACC_W-1:0]   r_fss, n_fss;
    logic               r_started, n_started;
    logic [5:0]         r_sec, n_sec, r_min, n_min;
    logic [6:0]         r_hr, n_hr;

    logic [15:0]        size;
    logic [15:0]        cnt;
    logic               close;
    logic               stamp;
    logic [ACC_W:0]     acc;
    logic [ACC_W:0]     acc_sub;
    logic signed [15:0] lmin_u, lmax_u, rmin_u, rmax_u;

    always_comb begin
        size   = (i_frames_per_block == 16'd0) ? 16'd1 : i_frames_per_block;
        cnt    = r_fib + 16'd1;
        close  = (cnt >= size) || i_eos;
        lmin_u = (i_left  < r_lmin) ? i_left  : r_lmin;
        lmax_u = (i_left  > r_lmax) ? i_left  : r_lmax;
        rmin_u = (i_right < r_rmin) ? i_right : r_rmin;
        rmax_u = (i_right > r_rmax) ? i_right : r_rmax;
        acc     = {1'b0, r_fss} + {{(ACC_W-15){1'b0}}, cnt};
        acc_sub = acc - {{(ACC_W-17){1'b0}}, i_frames_per_second};

        n_lmin    = r_lmin;
        n_lmax    = r_lmax;
        n_rmin    = r_rmin;
        n_rmax    = r_rmax;
        n_fib     = r_fib;
        n_fss     = r_fss;
        n_started = r_started;
        n_sec     = r_sec;
        n_min     = r_min;
        n_hr      = r_hr;
        stamp     = 1'b0;
        o_push    = 1'b0;
        o_row     = '0;

        if (i_accept) begin
            if (!close) begin
                n_lmin = lmin_u;
                n_lmax = lmax_u;
                n_rmin = rmin_u;
                n_rmax = rmax_u;
                n_fib  = cnt;
            end else begin
                o_push     = 1'b1;
                o_row.lmin = lmin_u;
                o_row.lmax = lmax_u;
                o_row.rmin = rmin_u;
                o_row.rmax = rmax_u;
                // short block: missing frames count as zero samples
                if (cnt < size) begin
                    if (lmin_u > 16'sd0) o_row.lmin = 16'sd0;
                    if (lmax_u < 16'sd0) o_row.lmax = 16'sd0;
                    if (rmin_u > 16'sd0) o_row.rmin = 16'sd0;
                    if (rmax_u < 16'sd0) o_row.rmax = 16'sd0;
                end

                if (!r_started) begin
                    n_started = 1'b1;
                    n_fss     = {{(ACC_W-16){1'b0}}, cnt};
                    stamp     = 1'b1;
                end else if (acc > {{(ACC_W-17){1'b0}}, i_frames_per_second}) begin
                    stamp = 1'b1;
                    n_fss = (acc_sub > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sub[ACC_W-1:0];
                    if (r_sec == LAST_SECOND) begin
                        n_sec = 6'd0;
                        if (r_min == LAST_MINUTE) begin
                            n_min = 6'd0;
                            n_hr  = (r_hr == LAST_HOUR) ? 7'd0 : r_hr + 7'd1;
                        end else begin
                            n_min = r_min + 6'd1;
                        end
                    end else begin
                        n_sec = r_sec + 6'd1;
                    end
                end else begin
                    n_fss = (acc > {1'b0, ACC_MAX}) ? ACC_MAX : acc[ACC_W-1:0];
                end

                o_row.stamp_valid = stamp;
                o_row.hours       = stamp ? n_hr  : 7'd0;
                o_row.minutes     = stamp ? n_min : 6'd0;
                o_row.seconds     = stamp ? n_sec : 6'd0;

                n_lmin = FULL_SCALE;
                n_lmax = -FULL_SCALE;
                n_rmin = FULL_SCALE;
                n_rmax = -FULL_SCALE;
                n_fib  = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmin    <= FULL_SCALE;
            r_lmax    <= -FULL_SCALE;
            r_rmin    <= FULL_SCALE;
            r_rmax    <= -FULL_SCALE;
            r_fib     <= 16'd0;
            r_fss     <= '0;
            r_started <= 1'b0;
            r_sec     <= 6'd0;
            r_min     <= 6'd0;
            r_hr      <= 7'd0;
        end else begin
            r_lmin    <= n_lmin;
            r_lmax    <= n_lmax;
            r_rmin    <= n_rmin;
            r_rmax    <= n_rmax;
            r_fib     <= n_fib;
            r_fss     <= n_fss;
            r_started <= n_started;
            r_sec     <= n_sec;
            r_min     <= n_min;
            r_hr      <= n_hr;
        end
    end

endmodule

[sv/sbpbm_fifo.sv]
// Short row queue between front and back end, held in flops.
// Depends on sbpbm_pkg.
module sbpbm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbpbm_pkg::t_row i_row,
    output logic            o_full,
    output sbpbm_pkg::t_hs  o_pop_hs,
    input  logic            i_pop,
    output sbpbm_pkg::t_row o_row
);
    import sbpbm_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_row             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_full         = (r_count == CNT_W'(FIFO_DEPTH));
        o_pop_hs.valid = (r_count != '0);
        o_pop_hs.ready = i_pop;
        do_push        = i_push && !o_full;
        do_pop         = i_pop && o_pop_hs.valid;
        o_row          = r_mem[r_rptr];
        n_wptr         = do_push ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr         = do_pop  ? r_rptr + PTR_W'(1) : r_rptr;
        n_count        = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[sv/sbpbm_back.sv]
// Back end: turns queued rows into bar columns, col = (W + W*x/32767)/2,
// over a multiply stage and an output register. Depends on sbpbm_pkg.
module sbpbm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_bar_width,
    input  sbpbm_pkg::t_hs  i_pop_hs,
    input  sbpbm_pkg::t_row i_row,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [55:0]     o_data,
    output logic            o_stamp_valid
);
    import sbpbm_pkg::*;

    typedef struct packed {
        logic signed [23:0] lmin;
        logic signed [23:0] lmax;
        logic signed [23:0] rmin;
        logic signed [23:0] rmax;
        logic               stamp_valid;
        logic [6:0]         hours;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
    } t_prod;

    // |p|/32767 = q0 + 1 when (|p| mod 32768) + q0 reaches 32767, q0 = |p| >> 15
    function automatic logic [7:0] column(input logic signed [23:0] p,
                                          input logic [7:0] w);
        logic [22:0] a;
        logic [7:0]  q0;
        logic [16:0] r;
        logic [8:0]  q;
        logic [8:0]  s;
        a  = p[23] ? 23'(-p) : p[22:0];
        q0 = a[22:15];
        r  = {2'b0, a[14:0]} + {9'b0, q0};
        q  = {1'b0, q0} + ((r >= 17'd32767) ? 9'd1 : 9'd0);
        s  = p[23] ? ({1'b0, w} - q) : ({1'b0, w} + q);
        return s[8:1];
    endfunction

    t_prod       r_s1, n_s1;
    logic        r_s1_valid;
    logic        r_out_valid;
    logic [55:0] r_data;
    logic        r_stamp;
    logic        out_load, s1_load;
    logic signed [8:0]  w_s;
    logic signed [24:0] p_lmin, p_lmax, p_rmin, p_rmax;

    always_comb begin
        out_load = r_s1_valid && (!r_out_valid || i_ready);
        s1_load  = !r_s1_valid || out_load;
        o_pop    = s1_load && i_pop_hs.valid;
        w_s      = $signed({1'b0, i_bar_width});
        p_lmin   = w_s * i_row.lmin;
        p_lmax   = w_s * i_row.lmax;
        p_rmin   = w_s * i_row.rmin;
        p_rmax   = w_s * i_row.rmax;
        n_s1.lmin        = p_lmin[23:0];
        n_s1.lmax        = p_lmax[23:0];
        n_s1.rmin        = p_rmin[23:0];
        n_s1.rmax        = p_rmax[23:0];
        n_s1.stamp_valid = i_row.stamp_valid;
        n_s1.hours       = i_row.hours;
        n_s1.minutes     = i_row.minutes;
        n_s1.seconds     = i_row.seconds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_pop_hs.valid && i_pop_hs.ready;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (out_load) begin
            r_data  <= {5'b0, r_s1.seconds, r_s1.minutes, r_s1.hours,
                        column(r_s1.rmax, i_bar_width), column(r_s1.rmin, i_bar_width),
                        column(r_s1.lmax, i_bar_width), column(r_s1.lmin, i_bar_width)};
            r_stamp <= r_s1.stamp_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_data        = r_data;
    assign o_stamp_valid = r_stamp;

endmodule

[sv/stereo_block_peak_bar_meter.sv]
// Top level of the stereo block peak bar meter: configuration registers,
// front end, row queue and back end. Depends on sbpbm_pkg and sbpbm_* modules.
//
//   channel  direction  handshake                       payload
//   s_axis   in         s_axis_tvalid / s_axis_tready   tdata {right, left}, tlast eos
//   m_axis   out        m_axis_tvalid / m_axis_tready   tdata columns+stamp, tuser
//   cfg      in         i_cfg_we (no handshake back)    i_cfg_addr, i_cfg_data
//
// One frame is taken every cycle while the row queue has room. A closing frame
// becomes a row in a 4-deep queue and reaches m_axis through the queue, the
// multiply stage and the output register. Reset is synchronous; no clearing pass.
// s_axis stalls only while the row queue is full; the output register lets
// the back end hold a result while the queue keeps filling.
module stereo_block_peak_bar_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] left_low_col, [15:8] left_high_col, [23:16] right_low_col,
    // [31:24] right_high_col, [38:32] stamp_hours, [44:39] stamp_minutes,
    // [50:45] stamp_seconds, [55:51] zero
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser,   // stamp_valid
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [17:0] i_cfg_data
);
    import sbpbm_pkg::*;

    logic [15:0] r_fpb;
    logic [7:0]  r_bw;
    logic [17:0] r_fps;

    logic  accept;
    logic  push;
    logic  full;
    logic  pop;
    t_row  row_in, row_out;
    t_hs   pop_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb <= FPB_RESET;
            r_bw  <= BW_RESET;
            r_fps <= FPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAMES_PER_BLOCK:  r_fpb <= i_cfg_data[15:0];
                CFG_BAR_WIDTH:         r_bw  <= i_cfg_data[7:0];
                CFG_FRAMES_PER_SECOND: r_fps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sbpbm_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_left              ($signed(s_axis_tdata[15:0])),
        .i_right             ($signed(s_axis_tdata[31:16])),
        .i_eos               (s_axis_tlast),
        .i_frames_per_block  (r_fpb),
        .i_frames_per_second (r_fps),
        .o_push              (push),
        .o_row               (row_in)
    );

    sbpbm_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_row    (row_in),
        .o_full   (full),
        .o_pop_hs (pop_hs),
        .i_pop    (pop),
        .o_row    (row_out)
    );

    sbpbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bar_width   (r_bw),
        .i_pop_hs      (pop_hs),
        .i_row         (row_out),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_stamp_valid (m_axis_tuser)
    );

endmodule

[sim/stereo_block_peak_bar_meter_tb.sv]
// Self-checking testbench for stereo_block_peak_bar_meter: random stereo frames in,
// bar rows out, each row checked against an in-bench bar/stamp tracker.
// Depends on sbpbm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module stereo_block_peak_bar_meter_tb;
    import sbpbm_pkg::*;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;   // unmapped register index

    typedef struct {
        logic [7:0] lo_l;
        logic [7:0] hi_l;
        logic [7:0] lo_r;
        logic [7:0] hi_r;
        logic       stamped;
        logic [6:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
    } t_bar_row;

    // Tracks per-channel extremes and the elapsed-time stamp, queues the rows due.
    class t_bar_row_tracker;
        logic [15:0] block_frames;
        logic [7:0]  bar_cols;
        logic [17:0] frame_rate;
        int          lmin, lmax, rmin, rmax;
        int unsigned held, since_stamp;
        bit          started;
        int unsigned secs, mins, hrs;
        t_bar_row    rows_due[$];
        int          errors;

        function new();
            block_frames = FPB_RESET;
            bar_cols     = BW_RESET;
            frame_rate   = FPS_RESET;
            since_stamp  = 0;
            started      = 0;
            secs         = 0;
            mins         = 0;
            hrs          = 0;
            errors       = 0;
            clear_block();
        endfunction

        function void clear_block();
            lmin = int'(FULL_SCALE);
            lmax = -int'(FULL_SCALE);
            rmin = int'(FULL_SCALE);
            rmax = -int'(FULL_SCALE);
            held = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [17:0] val);
            case (idx)
                CFG_FRAMES_PER_BLOCK:  block_frames = val[15:0];
                CFG_BAR_WIDTH:         bar_cols = val[7:0];
                CFG_FRAMES_PER_SECOND: frame_rate = val;
                default: ;
            endcase
        endfunction

        // (W + W*x/32767)/2, division truncating toward zero
        function logic [7:0] bar_column(int x);
            int w;
            int c;
            w = bar_cols;
            c = (w + (w * x) / int'(FULL_SCALE)) / 2;
            if (c < 0)
                c = 0;
            return c[7:0];
        endfunction

        function void tick_second();
            if (secs == LAST_SECOND) begin
                secs = 0;
                if (mins == LAST_MINUTE) begin
                    mins = 0;
                    hrs = (hrs == LAST_HOUR) ? 0 : hrs + 1;
                end else begin
                    mins++;
                end
            end else begin
                secs++;
            end
        endfunction

        function void take_frame(logic signed [15:0] l, logic signed [15:0] r, bit eos);
            int unsigned size;
            int unsigned n;
            int unsigned acc;
            bit          stamp;
            t_bar_row    row;
            size = (block_frames == 0) ? 1 : block_frames;
            if (l < lmin) lmin = l;
            if (l > lmax) lmax = l;
            if (r < rmin) rmin = r;
            if (r > rmax) rmax = r;
            held++;
            if (held < size && !eos)
                return;
            n = held;
            stamp = 0;
            // short block: missing frames count as zero samples
            if (n < size) begin
                if (lmin > 0) lmin = 0;
                if (lmax < 0) lmax = 0;
                if (rmin > 0) rmin = 0;
                if (rmax < 0) rmax = 0;
            end
            if (!started) begin
                started = 1;
                since_stamp = n;
                stamp = 1;
            end else begin
                acc = since_stamp + n;
                if (acc > frame_rate) begin
                    acc -= frame_rate;
                    tick_second();
                    stamp = 1;
                end
                if (acc > ACC_MAX)
                    acc = ACC_MAX;
                since_stamp = acc;
            end
            row.lo_l    = bar_column(lmin);
            row.hi_l    = bar_column(lmax);
            row.lo_r    = bar_column(rmin);
            row.hi_r    = bar_column(rmax);
            row.stamped = stamp;
            row.hh      = stamp ? hrs[6:0] : '0;
            row.mm      = stamp ? mins[5:0] : '0;
            row.ss      = stamp ? secs[5:0] : '0;
            rows_due.push_back(row);
            clear_block();
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void match_row(logic [55:0] d, logic stamp_flag);
            t_bar_row want;
            if (rows_due.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: row expected none actual %h/%b", $time, d, stamp_flag);
                return;
            end
            want = rows_due.pop_front();
            compare("left_low_col", want.lo_l, d[7:0]);
            compare("left_high_col", want.hi_l, d[15:8]);
            compare("right_low_col", want.lo_r, d[23:16]);
            compare("right_high_col", want.hi_r, d[31:24]);
            compare("stamp_hours", want.hh, d[38:32]);
            compare("stamp_minutes", want.mm, d[44:39]);
            compare("stamp_seconds", want.ss, d[50:45]);
            compare("pad", 0, d[55:51]);
            compare("stamp_valid", want.stamped, stamp_flag);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [17:0] i_cfg_data;

    t_bar_row_tracker meter;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_cycles = 0;

    stereo_block_peak_bar_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, bit eos);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        meter.take_frame(l, r, eos);
    endtask

    task automatic send_random(int count, int eos_pct);
        repeat (count)
            send_frame(pick_sample(), pick_sample(), $urandom_range(99) < eos_pct);
    endtask

    // all rows out, then a wait so a frame that closed no block is absorbed
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (meter.rows_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [17:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        meter.set_reg(idx, val);
    endtask

    task automatic apply_config(logic [15:0] fpb, logic [7:0] bw, logic [17:0] fps);
        settle();
        cfg_write(CFG_FRAMES_PER_BLOCK, 18'(fpb));
        cfg_write(CFG_BAR_WIDTH, 18'(bw));
        cfg_write(CFG_FRAMES_PER_SECOND, fps);
        cfg_write(CFG_SPARE_IDX, 18'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // row sink: checks accepted rows, stalls at random or for a long hold
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                meter.match_row(m_axis_tdata, m_axis_tuser);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        logic [15:0] blk;
        logic [7:0]  cols;
        logic [17:0] rate;
        int          seg;
        meter = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings; short block closed by end of stream, first stamp
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sd5, -16'sd5, 1'b1);

        apply_config(16'd1, 8'd255, FPS_RESET);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(-16'sd1, 16'sd1, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b0);

        // zero frame rate stamps every row
        apply_config(16'd1, 8'd255, 18'd0);
        send_frame(16'sd1234, -16'sd1234, 1'b0);
        send_frame(-16'sd7, 16'sd7, 1'b0);

        apply_config(16'd1, 8'd0, 18'd0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);

        // block size zero acts as one
        apply_config(16'd0, 8'd1, 18'd1);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sd100, 16'sd100, 1'b0);

        // block size lowered while a block is partly full
        apply_config(16'd8, 8'd17, 18'd3);
        send_random(5, 0);
        apply_config(16'd3, 8'd17, 18'd3);
        send_random(1, 0);

        // largest block closed early: padding zeros pull the extremes to zero
        apply_config(16'hffff, 8'd1, 18'h3ffff);
        send_frame(16'sd100, -16'sd200, 1'b0);
        send_frame(16'sd300, -16'sd50, 1'b1);

        for (seg = 0; seg < 12; seg++) begin
            case ($urandom_range(9))
                0:       blk = 16'd0;
                9:       blk = 16'hffff;
                7, 8:    blk = 16'($urandom_range(40, 5));
                default: blk = 16'($urandom_range(4, 1));
            endcase
            case ($urandom_range(5))
                0:       cols = 8'd0;
                1:       cols = 8'd1;
                2:       cols = 8'd255;
                default: cols = 8'($urandom_range(255));
            endcase
            case ($urandom_range(5))
                0:       rate = 18'd0;
                1:       rate = 18'd1;
                2:       rate = 18'h3ffff;
                default: rate = 18'($urandom_range(20, 1));
            endcase
            if (seg == 4)
                blk = 16'd1;
            apply_config(blk, cols, rate);
            case (seg % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            // one row per frame while the sink holds off: row queue fills, input stalls
            if (seg == 4)
                hold_cycles = 300;
            send_random(150, 4);
        end

        // zero frame rate: every row stamped, seconds roll over into minutes
        apply_config(16'd1, 8'd200, 18'd0);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random(80, 0);

        settle();
        if (meter.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/sbpbm_pkg.sv
sv/sbpbm_front.sv
sv/sbpbm_fifo.sv
sv/sbpbm_back.sv
sv/stereo_block_peak_bar_meter.sv
sim/stereo_block_peak_bar_meter_tb.sv
